[hw/rtl/rsob_pkg.sv]
// Shared types, constants and saturating fixed-point helpers of the ray caster.
package rsob_pkg;

  localparam int QW          = 48;
  localparam int MAX_SPHERES = 16;
  localparam int MAX_BOXES   = 16;
  localparam int SPH_WORDS   = 4;
  localparam int BOX_WORDS   = 15;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam q_t QMIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_SPH = 2'd0,
    OP_LOAD_BOX = 2'd1,
    OP_CAST     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef enum logic [1:0] {
    VEC_MV  = 2'd0,
    VEC_DIR = 2'd1,
    VEC_L   = 2'd2,
    VEC_AX  = 2'd3
  } vec_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DOT, S_DOT_ACC, S_WAIT, S_LEN_SQ, S_LEN_DONE, S_DIR, S_DIR_DONE,
    S_SPH_NEXT, S_BOX_NEXT, S_FETCH, S_SPH_L, S_SPH_TCA, S_SPH_LL, S_SPH_TT,
    S_SPH_R2, S_SPH_SQ, S_BOX_D, S_BOX_AX, S_BOX_E, S_BOX_F, S_BOX_T1, S_BOX_T2,
    S_OUT, S_OUT_DONE, S_RESULT
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    q_t      a;
    q_t      b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    q_t   res;
  } alu_rsp_t;

  function automatic q_t qadd(q_t a, q_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? QMIN : QMAX;
    return s[QW-1:0];
  endfunction

  function automatic q_t qsub(q_t a, q_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? QMIN : QMAX;
    return s[QW-1:0];
  endfunction

  function automatic q_t sx32(logic [31:0] v);
    return {{(QW-32){v[31]}}, v};
  endfunction

  function automatic logic [31:0] out_coord(q_t v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Applies a sign to an unsigned magnitude and clamps to the Q31.16 range.
  function automatic q_t signed_mag(logic neg, logic [79:0] mag);
    if (neg) begin
      if (mag > 80'h8000_0000_0000) return QMIN;
      return -$signed(mag[QW-1:0]);
    end
    if (mag > 80'h7FFF_FFFF_FFFF) return QMAX;
    return $signed(mag[QW-1:0]);
  endfunction

endpackage

[hw/rtl/ray_sphere_obb_first_hit.sv]
// Top level of the first-hit ray caster against a sphere table and a box table.
//
// The block holds up to 16 spheres (center, radius) and 16 oriented boxes
// (center, three axes, three half lengths) in two RAMs that are loaded one
// Q16.16 word per input item (tuser 0 for a sphere word, 1 for a box word).
// A cast item (tuser 2) brings a ray origin and a move vector; the block
// normalizes the move vector, tests spheres 0..sphere_count-1 and then boxes
// 0..box_count-1 in order, and returns one result item for the first entry
// hit, which need not be the nearest one. All multiplies, divides and square
// roots of a cast run one at a time on a single shared unit, so the time a
// cast takes grows with the number of entries walked.
// The input is not ready while a cast is in progress. A finished result sits
// in an output register, so loads and the next cast can be taken while it
// waits to be read.
module ray_sphere_obb_first_hit (
  input  logic         clk,
  input  logic         rst_n,
  // tuser: operation[1:0]
  // tdata: entry_index[3:0], word_index[7:4], word_value[39:8],
  //        origin_x[71:40], origin_y[103:72], origin_z[135:104],
  //        move_x[167:136], move_y[199:168], move_z[231:200]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [231:0] in_tdata,
  input  logic [1:0]   in_tuser,
  // tuser: hit[0], hit_kind[1]
  // tdata: hit_index[3:0], clipped_x[35:4], clipped_y[67:36],
  //        clipped_z[99:68], zero[103:100]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,
  output logic [1:0]   out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rsob_pkg::*;

  // Configuration registers.
  logic [4:0] sph_cnt_r, box_cnt_r;
  logic [4:0] ns, nb;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'h0, box_cnt_r} : {27'h0, sph_cnt_r};
  assign ns     = (sph_cnt_r > 5'd16) ? 5'd16 : sph_cnt_r;
  assign nb     = (box_cnt_r > 5'd16) ? 5'd16 : box_cnt_r;

  // Sequencer state.
  state_t   state_r, state_nxt, ret_r, ret_nxt, dret_r, dret_nxt;
  vec_sel_t va_r, va_nxt, vb_r, vb_nxt;
  logic [1:0] dk_r, dk_nxt, k_r, k_nxt, ax_r, ax_nxt;
  logic [3:0] fc_r, fc_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       kind_r, kind_nxt, found_r, found_nxt;

  // Datapath registers.
  q_t org_r [3];
  q_t mv_r  [3];
  q_t dir_r [3], dir_nxt [3];
  q_t lv_r  [3], lv_nxt  [3];
  q_t ent_r [BOX_WORDS], ent_nxt [BOX_WORDS];
  logic [31:0] clip_r [3], clip_nxt [3];
  q_t len_r, len_nxt, acc_r, acc_nxt, tca_r, tca_nxt, e_r, e_nxt, f_r, f_nxt;
  q_t tt_r, tt_nxt, tmin_r, tmin_nxt, tmax_r, tmax_nxt, t_r, t_nxt;

  // Output register.
  logic        out_valid_r, out_hit_r, out_kind_r;
  logic [3:0]  out_idx_r;
  logic [31:0] out_c_r [3];

  // Input item fields.
  op_t        in_op;
  logic [3:0] in_ent, in_wd;
  logic [31:0] in_val;
  logic       in_acc, out_acc, cfg_wr;

  assign in_op   = op_t'(in_tuser);
  assign in_ent  = in_tdata[3:0];
  assign in_wd   = in_tdata[7:4];
  assign in_val  = in_tdata[39:8];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Table RAMs: loads write them while idle, the entry fetch reads them.
  logic        sph_we, box_we;
  logic [5:0]  sph_waddr, sph_raddr;
  logic [7:0]  box_waddr, box_raddr;
  logic [31:0] sph_rdata, box_rdata, rdata;

  assign sph_we    = in_acc && in_op == OP_LOAD_SPH && in_wd < 4'(SPH_WORDS);
  assign box_we    = in_acc && in_op == OP_LOAD_BOX && in_wd < 4'(BOX_WORDS);
  assign sph_waddr = {in_ent, in_wd[1:0]};
  assign box_waddr = {in_ent, 4'h0} - {4'h0, in_ent} + {4'h0, in_wd};
  assign sph_raddr = {idx_r[3:0], fc_r[1:0]};
  assign box_raddr = {idx_r[3:0], 4'h0} - {4'h0, idx_r[3:0]} + {4'h0, fc_r};
  assign rdata     = kind_r ? box_rdata : sph_rdata;

  rsob_ram #(.W(32), .D(MAX_SPHERES * SPH_WORDS)) u_sph_ram (
    .clk(clk), .we(sph_we), .waddr(sph_waddr), .wdata(in_val),
    .raddr(sph_raddr), .rdata(sph_rdata)
  );

  rsob_ram #(.W(32), .D(MAX_BOXES * BOX_WORDS)) u_box_ram (
    .clk(clk), .we(box_we), .waddr(box_waddr), .wdata(in_val),
    .raddr(box_raddr), .rdata(box_rdata)
  );

  // Shared arithmetic unit.
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  q_t       alu_res;

  rsob_alu u_alu (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));
  assign alu_res = alu_rsp.res;

  // Operand selection for the dot product walk.
  logic [3:0] ax_base, axi;
  q_t va_el, vb_el, h_el, dot_val;

  always_comb begin
    case (ax_r)
      2'd0:    ax_base = 4'd3;
      2'd1:    ax_base = 4'd6;
      default: ax_base = 4'd9;
    endcase
    axi = ax_base + {2'b00, dk_r};
    h_el = ent_r[4'd12 + {2'b00, ax_r}];
    case (va_r)
      VEC_MV:  va_el = mv_r[dk_r];
      VEC_DIR: va_el = dir_r[dk_r];
      VEC_L:   va_el = lv_r[dk_r];
      default: va_el = ent_r[axi];
    endcase
    case (vb_r)
      VEC_MV:  vb_el = mv_r[dk_r];
      VEC_DIR: vb_el = dir_r[dk_r];
      VEC_L:   vb_el = lv_r[dk_r];
      default: vb_el = ent_r[axi];
    endcase
  end

  assign dot_val = (dk_r == 2'd0) ? alu_res : qadd(acc_r, alu_res);

  // Decisions of the sphere and slab tests.
  q_t   neg_e, t1, t2, slo, shi, nmin, nmax;
  logic sph_miss, par_fail, slab_fail, nw_done;

  assign sph_miss  = f_r > alu_res;
  assign neg_e     = qsub('0, e_r);
  assign par_fail  = (qsub(neg_e, h_el) > 0) || qadd(neg_e, h_el)[47];
  assign t1        = tt_r;
  assign t2        = alu_res;
  assign slo       = (t1 > t2) ? t2 : t1;
  assign shi       = (t1 > t2) ? t1 : t2;
  assign nmin      = (slo > tmin_r) ? slo : tmin_r;
  assign nmax      = (shi < tmax_r) ? shi : tmax_r;
  assign slab_fail = (nmin > nmax) || nmax[47] || (nmin > len_r);
  assign nw_done   = kind_r ? (fc_r == 4'(BOX_WORDS)) : (fc_r == 4'(SPH_WORDS));

  // Next state of the sequencer, with its two return registers.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    dret_nxt  = dret_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_CAST) begin
          dret_nxt  = S_LEN_SQ;
          state_nxt = S_DOT;
        end
      end
      S_DOT: begin
        ret_nxt   = S_DOT_ACC;
        state_nxt = S_WAIT;
      end
      S_DOT_ACC:  state_nxt = (dk_r == 2'd2) ? dret_r : S_DOT;
      S_WAIT:     if (alu_rsp.done) state_nxt = ret_r;
      S_LEN_SQ: begin
        ret_nxt   = S_LEN_DONE;
        state_nxt = S_WAIT;
      end
      S_LEN_DONE: state_nxt = S_DIR;
      S_DIR: begin
        if (len_r == '0) begin
          state_nxt = S_SPH_NEXT;
        end else begin
          ret_nxt   = S_DIR_DONE;
          state_nxt = S_WAIT;
        end
      end
      S_DIR_DONE: state_nxt = (k_r == 2'd2) ? S_SPH_NEXT : S_DIR;
      S_SPH_NEXT: state_nxt = (idx_r < ns) ? S_FETCH : S_BOX_NEXT;
      S_BOX_NEXT: state_nxt = (idx_r < nb) ? S_FETCH : S_RESULT;
      S_FETCH: begin
        if (nw_done) state_nxt = kind_r ? S_BOX_D : S_SPH_L;
      end
      S_SPH_L: begin
        dret_nxt  = S_SPH_TCA;
        state_nxt = S_DOT;
      end
      S_SPH_TCA: begin
        if (acc_r[47]) begin
          state_nxt = S_SPH_NEXT;
        end else begin
          dret_nxt  = S_SPH_LL;
          state_nxt = S_DOT;
        end
      end
      S_SPH_LL: begin
        ret_nxt   = S_SPH_TT;
        state_nxt = S_WAIT;
      end
      S_SPH_TT: begin
        ret_nxt   = S_SPH_R2;
        state_nxt = S_WAIT;
      end
      S_SPH_R2: begin
        if (sph_miss) begin
          state_nxt = S_SPH_NEXT;
        end else begin
          ret_nxt   = S_SPH_SQ;
          state_nxt = S_WAIT;
        end
      end
      S_SPH_SQ:   state_nxt = S_OUT;
      S_BOX_D:    state_nxt = S_BOX_AX;
      S_BOX_AX: begin
        dret_nxt  = S_BOX_E;
        state_nxt = S_DOT;
      end
      S_BOX_E: begin
        dret_nxt  = S_BOX_F;
        state_nxt = S_DOT;
      end
      S_BOX_F: begin
        if (acc_r != '0) begin
          ret_nxt   = S_BOX_T1;
          state_nxt = S_WAIT;
        end else if (par_fail) begin
          state_nxt = S_BOX_NEXT;
        end else begin
          state_nxt = (ax_r == 2'd2) ? S_OUT : S_BOX_AX;
        end
      end
      S_BOX_T1: begin
        ret_nxt   = S_BOX_T2;
        state_nxt = S_WAIT;
      end
      S_BOX_T2: begin
        if (slab_fail) state_nxt = S_BOX_NEXT;
        else           state_nxt = (ax_r == 2'd2) ? S_OUT : S_BOX_AX;
      end
      S_OUT: begin
        ret_nxt   = S_OUT_DONE;
        state_nxt = S_WAIT;
      end
      S_OUT_DONE: state_nxt = (k_r == 2'd2) ? S_RESULT : S_OUT;
      S_RESULT:   if (!out_valid_r || out_acc) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and shared unit requests for each state.
  always_comb begin
    va_nxt    = va_r;
    vb_nxt    = vb_r;
    dk_nxt    = dk_r;
    k_nxt     = k_r;
    ax_nxt    = ax_r;
    fc_nxt    = fc_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    found_nxt = found_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    tca_nxt   = tca_r;
    e_nxt     = e_r;
    f_nxt     = f_r;
    tt_nxt    = tt_r;
    tmin_nxt  = tmin_r;
    tmax_nxt  = tmax_r;
    t_nxt     = t_r;
    dir_nxt   = dir_r;
    lv_nxt    = lv_r;
    ent_nxt   = ent_r;
    clip_nxt  = clip_r;
    alu_req   = '0;
    alu_req.op = ALU_MUL;
    case (state_r)
      S_IDLE: begin
        va_nxt    = VEC_MV;
        vb_nxt    = VEC_MV;
        dk_nxt    = 2'd0;
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      S_DOT: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = va_el;
        alu_req.b     = vb_el;
      end
      S_DOT_ACC: begin
        acc_nxt = dot_val;
        dk_nxt  = (dk_r == 2'd2) ? 2'd0 : dk_r + 2'd1;
      end
      S_LEN_SQ: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_req.a     = acc_r;
      end
      S_LEN_DONE: begin
        len_nxt = alu_res;
        k_nxt   = 2'd0;
      end
      S_DIR: begin
        if (len_r == '0) begin
          for (int i = 0; i < 3; i++) dir_nxt[i] = '0;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.a     = mv_r[k_r];
          alu_req.b     = len_r;
        end
      end
      S_DIR_DONE: begin
        dir_nxt[k_r] = alu_res;
        k_nxt        = k_r + 2'd1;
      end
      S_SPH_NEXT: begin
        fc_nxt = '0;
        if (idx_r < ns) kind_nxt = 1'b0;
        else            idx_nxt  = '0;
      end
      S_BOX_NEXT: begin
        fc_nxt = '0;
        if (idx_r < nb) kind_nxt = 1'b1;
      end
      S_FETCH: begin
        // Read data is registered, so it belongs to the address of the previous cycle.
        if (fc_r != '0) ent_nxt[fc_r - 4'd1] = sx32(rdata);
        fc_nxt = nw_done ? 4'd0 : fc_r + 4'd1;
      end
      S_SPH_L, S_BOX_D: begin
        for (int i = 0; i < 3; i++) lv_nxt[i] = qsub(ent_r[i], org_r[i]);
        va_nxt   = VEC_L;
        vb_nxt   = VEC_DIR;
        tmin_nxt = QMIN;
        tmax_nxt = QMAX;
        ax_nxt   = 2'd0;
      end
      S_SPH_TCA: begin
        tca_nxt = acc_r;
        va_nxt  = VEC_L;
        vb_nxt  = VEC_L;
        if (acc_r[47]) idx_nxt = idx_r + 5'd1;
      end
      S_SPH_LL: begin
        e_nxt         = acc_r;
        alu_req.start = 1'b1;
        alu_req.a     = tca_r;
        alu_req.b     = tca_r;
      end
      S_SPH_TT: begin
        f_nxt         = qsub(e_r, alu_res);
        alu_req.start = 1'b1;
        alu_req.a     = ent_r[3];
        alu_req.b     = ent_r[3];
      end
      S_SPH_R2: begin
        if (sph_miss) begin
          idx_nxt = idx_r + 5'd1;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_SQRT;
          alu_req.a     = qsub(alu_res, f_r);
        end
      end
      S_SPH_SQ: begin
        t_nxt     = qsub(tca_r, alu_res);
        found_nxt = 1'b1;
        k_nxt     = 2'd0;
      end
      S_BOX_AX: begin
        va_nxt = VEC_AX;
        vb_nxt = VEC_L;
      end
      S_BOX_E: begin
        e_nxt  = acc_r;
        va_nxt = VEC_AX;
        vb_nxt = VEC_DIR;
      end
      S_BOX_F: begin
        f_nxt = acc_r;
        if (acc_r != '0) begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.a     = qadd(e_r, h_el);
          alu_req.b     = acc_r;
        end else if (par_fail) begin
          idx_nxt = idx_r + 5'd1;
        end else if (ax_r == 2'd2) begin
          t_nxt     = tmin_r;
          found_nxt = 1'b1;
          k_nxt     = 2'd0;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      S_BOX_T1: begin
        tt_nxt        = alu_res;
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = qsub(e_r, h_el);
        alu_req.b     = f_r;
      end
      S_BOX_T2: begin
        tmin_nxt = nmin;
        tmax_nxt = nmax;
        if (slab_fail) begin
          idx_nxt = idx_r + 5'd1;
        end else if (ax_r == 2'd2) begin
          t_nxt     = nmin;
          found_nxt = 1'b1;
          k_nxt     = 2'd0;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      S_OUT: begin
        alu_req.start = 1'b1;
        alu_req.a     = dir_r[k_r];
        alu_req.b     = t_r;
      end
      S_OUT_DONE: begin
        clip_nxt[k_r] = out_coord(alu_res);
        k_nxt         = k_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sph_cnt_r   <= '0;
      box_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2]) box_cnt_r <= pwdata[4:0];
        else          sph_cnt_r <= pwdata[4:0];
      end
      if (state_r == S_RESULT && (!out_valid_r || out_acc)) out_valid_r <= 1'b1;
      else if (out_acc)                                      out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;
    dret_r  <= dret_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    dk_r    <= dk_nxt;
    k_r     <= k_nxt;
    ax_r    <= ax_nxt;
    fc_r    <= fc_nxt;
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    found_r <= found_nxt;
    len_r   <= len_nxt;
    acc_r   <= acc_nxt;
    tca_r   <= tca_nxt;
    e_r     <= e_nxt;
    f_r     <= f_nxt;
    tt_r    <= tt_nxt;
    tmin_r  <= tmin_nxt;
    tmax_r  <= tmax_nxt;
    t_r     <= t_nxt;
    dir_r   <= dir_nxt;
    lv_r    <= lv_nxt;
    ent_r   <= ent_nxt;
    clip_r  <= clip_nxt;
    if (in_acc && in_op == OP_CAST) begin
      org_r[0] <= sx32(in_tdata[71:40]);
      org_r[1] <= sx32(in_tdata[103:72]);
      org_r[2] <= sx32(in_tdata[135:104]);
      mv_r[0]  <= sx32(in_tdata[167:136]);
      mv_r[1]  <= sx32(in_tdata[199:168]);
      mv_r[2]  <= sx32(in_tdata[231:200]);
    end
    if (state_r == S_RESULT && (!out_valid_r || out_acc)) begin
      // A miss reports zero in every field.
      out_hit_r  <= found_r;
      out_kind_r <= found_r & kind_r;
      out_idx_r  <= found_r ? idx_r[3:0] : 4'h0;
      for (int i = 0; i < 3; i++) out_c_r[i] <= found_r ? clip_r[i] : 32'h0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_kind_r, out_hit_r};
  assign out_tdata  = {4'h0, out_c_r[2], out_c_r[1], out_c_r[0], out_idx_r};

endmodule

[hw/rtl/rsob_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module rsob_ram #(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rsob_alu.sv]
// Shared multi-cycle unit: saturating Q31.16 multiply, divide and square root.
module rsob_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  rsob_pkg::alu_req_t req,
  output rsob_pkg::alu_rsp_t rsp
);
  import rsob_pkg::*;

  alu_op_t     op_r;
  logic        busy_r, done_r, neg_r;
  logic [6:0]  cnt_r;
  logic [47:0] ma_r, mb_r;
  logic [95:0] macc_r;
  logic [48:0] rem_r;
  logic [63:0] quo_r, sqn_r, sqres_r, sqbit_r;
  q_t          res_r;

  logic [47:0] ua, ub;
  logic [48:0] rem_sh;
  logic [63:0] sq_try;

  assign ua     = req.a[47] ? 48'(-req.a) : 48'(req.a);
  assign ub     = req.b[47] ? 48'(-req.b) : 48'(req.b);
  assign rem_sh = {rem_r[47:0], quo_r[63]};
  assign sq_try = sqres_r + sqbit_r;

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r  <= req.op;
        neg_r <= req.a[47] ^ req.b[47];
        case (req.op)
          ALU_MUL: begin
            ma_r   <= ua;
            mb_r   <= ub;
            macc_r <= '0;
            cnt_r  <= 7'd3;
            busy_r <= 1'b1;
          end
          ALU_DIV: begin
            if (ub == '0) begin
              res_r  <= '0;
              done_r <= 1'b1;
            end else begin
              mb_r   <= ub;
              rem_r  <= '0;
              quo_r  <= {ua, 16'h0000};
              cnt_r  <= 7'd64;
              busy_r <= 1'b1;
            end
          end
          default: begin
            if (req.a[47] || req.a == '0) begin
              res_r  <= '0;
              done_r <= 1'b1;
            end else begin
              sqn_r   <= {req.a, 16'h0000};
              sqres_r <= '0;
              sqbit_r <= 64'h4000_0000_0000_0000;
              cnt_r   <= 7'd32;
              busy_r  <= 1'b1;
            end
          end
        endcase
      end else if (busy_r && cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        case (op_r)
          ALU_MUL: begin
            // Sixteen multiplier bits per cycle, most significant chunk first.
            macc_r <= (macc_r << 16) + {32'h0, ma_r * mb_r[47:32]};
            mb_r   <= mb_r << 16;
          end
          ALU_DIV: begin
            if (rem_sh >= {1'b0, mb_r}) begin
              rem_r <= rem_sh - {1'b0, mb_r};
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[62:0], 1'b0};
            end
          end
          default: begin
            if (sqn_r >= sq_try) begin
              sqn_r   <= sqn_r - sq_try;
              sqres_r <= (sqres_r >> 1) + sqbit_r;
            end else begin
              sqres_r <= sqres_r >> 1;
            end
            sqbit_r <= sqbit_r >> 2;
          end
        endcase
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        case (op_r)
          ALU_MUL: res_r <= signed_mag(neg_r, macc_r[95:16]);
          ALU_DIV: res_r <= signed_mag(neg_r, {16'h0000, quo_r});
          default: res_r <= $signed(sqres_r[47:0]);
        endcase
      end
    end
  end

endmodule

[test/ray_sphere_obb_first_hit_check.sv]
// Watches the ray caster's channels, predicts each cast's hit and compares it.
`timescale 1ns / 100ps
module ray_sphere_obb_first_hit_check
  import rsob_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [231:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           errors,
  output int           pending
);

  localparam logic [2:0] ADDR_SPHERE_COUNT = 3'd0;
  localparam logic [2:0] ADDR_BOX_COUNT    = 3'd4;
  localparam longint FX_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FX_MIN = -FX_MAX - 1;

  typedef struct packed {
    logic        hit;
    logic        kind;
    logic [3:0]  index;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
  } hit_t;

  longint sph_words [MAX_SPHERES*SPH_WORDS];
  longint box_words [MAX_BOXES*BOX_WORDS];
  logic [4:0] n_spheres, n_boxes;
  hit_t hit_queue[$];
  int mismatches;

  function automatic longint fx_sat(longint v);
    if (v > FX_MAX) return FX_MAX;
    if (v < FX_MIN) return FX_MIN;
    return v;
  endfunction

  function automatic longint fx_mag(logic neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'h8000_0000_0000) return FX_MIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) return FX_MAX;
    return longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] ua, ub;
    logic [127:0] p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    return fx_mag((a < 0) != (b < 0), p >> 16);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [63:0] ua, ub;
    logic [127:0] q;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ub == 0) return 0;
    q = ({64'd0, ua} << 16) / {64'd0, ub};
    return fx_mag((a < 0) != (b < 0), q);
  endfunction

  // Floor square root of a Q31.16 value, bit by bit.
  function automatic longint fx_sqrt(longint x);
    logic [63:0] n, res, b;
    if (x <= 0) return 0;
    n = 64'(x) << 16;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint fx_dot(longint a0, longint a1, longint a2,
                                    longint b0, longint b1, longint b2);
    return fx_sat(fx_sat(fx_mul(a0, b0) + fx_mul(a1, b1)) + fx_mul(a2, b2));
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint sx(logic [31:0] w);
    return longint'($signed(w));
  endfunction

  // Slab test of one box; returns the entry distance through tmin_o.
  function automatic logic box_hit(int base, longint org[3], longint dir[3], longint len,
                                   output longint tmin_o);
    longint d[3];
    longint tmin, tmax, h, e, f, t1, t2, s, ne;
    int a;
    tmin = FX_MIN;
    tmax = FX_MAX;
    tmin_o = 0;
    for (int k = 0; k < 3; k++) d[k] = fx_sat(box_words[base+k] - org[k]);
    for (int i = 0; i < 3; i++) begin
      a = base + 3 + 3*i;
      h = box_words[base+12+i];
      e = fx_dot(box_words[a], box_words[a+1], box_words[a+2], d[0], d[1], d[2]);
      f = fx_dot(box_words[a], box_words[a+1], box_words[a+2], dir[0], dir[1], dir[2]);
      if (f != 0) begin
        t1 = fx_div(fx_sat(e + h), f);
        t2 = fx_div(fx_sat(e - h), f);
        if (t1 > t2) begin
          s = t1; t1 = t2; t2 = s;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax || tmax < 0 || tmin > len) return 1'b0;
      end else begin
        // Parallel axis: the origin must lie within the slab.
        ne = fx_sat(-e);
        if (fx_sat(ne - h) > 0 || fx_sat(ne + h) < 0) return 1'b0;
      end
    end
    tmin_o = tmin;
    return 1'b1;
  endfunction

  function automatic hit_t cast_ray(logic [231:0] d);
    longint org[3], mv[3], dir[3];
    longint len, t, tca, d2, r2, l0, l1, l2, tb;
    int ns, nb, base;
    hit_t r;
    r = '0;
    t = 0;
    for (int k = 0; k < 3; k++) begin
      org[k] = sx(d[40+32*k +: 32]);
      mv[k]  = sx(d[136+32*k +: 32]);
    end
    len = fx_sqrt(fx_dot(mv[0], mv[1], mv[2], mv[0], mv[1], mv[2]));
    for (int k = 0; k < 3; k++) dir[k] = (len == 0) ? 0 : fx_div(mv[k], len);
    ns = (n_spheres > MAX_SPHERES) ? MAX_SPHERES : n_spheres;
    nb = (n_boxes > MAX_BOXES) ? MAX_BOXES : n_boxes;
    for (int i = 0; i < ns && !r.hit; i++) begin
      base = i*SPH_WORDS;
      l0 = fx_sat(sph_words[base] - org[0]);
      l1 = fx_sat(sph_words[base+1] - org[1]);
      l2 = fx_sat(sph_words[base+2] - org[2]);
      tca = fx_dot(l0, l1, l2, dir[0], dir[1], dir[2]);
      if (tca >= 0) begin
        d2 = fx_sat(fx_dot(l0, l1, l2, l0, l1, l2) - fx_mul(tca, tca));
        r2 = fx_mul(sph_words[base+3], sph_words[base+3]);
        if (d2 <= r2) begin
          // A negative t (origin inside the sphere) is kept as it is.
          t = fx_sat(tca - fx_sqrt(fx_sat(r2 - d2)));
          r.hit = 1'b1;
          r.kind = 1'b0;
          r.index = i[3:0];
        end
      end
    end
    for (int i = 0; i < nb && !r.hit; i++) begin
      if (box_hit(i*BOX_WORDS, org, dir, len, tb)) begin
        t = tb;
        r.hit = 1'b1;
        r.kind = 1'b1;
        r.index = i[3:0];
      end
    end
    if (r.hit) begin
      r.cx = clip32(fx_mul(dir[0], t));
      r.cy = clip32(fx_mul(dir[1], t));
      r.cz = clip32(fx_mul(dir[2], t));
    end
    return r;
  endfunction

  initial begin
    foreach (sph_words[i]) sph_words[i] = 0;
    foreach (box_words[i]) box_words[i] = 0;
    n_spheres = 0;
    n_boxes = 0;
    mismatches = 0;
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    hit_t want, got;
    logic [3:0] ent, wd;
    if (!rst_n) begin
      n_spheres = 0;
      n_boxes = 0;
      hit_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_SPHERE_COUNT: n_spheres = pwdata[4:0];
          ADDR_BOX_COUNT:    n_boxes = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        ent = in_tdata[3:0];
        wd = in_tdata[7:4];
        case (op_t'(in_tuser))
          OP_LOAD_SPH:
            if (wd < SPH_WORDS) sph_words[ent*SPH_WORDS + wd] = sx(in_tdata[39:8]);
          OP_LOAD_BOX:
            if (wd < BOX_WORDS) box_words[ent*BOX_WORDS + wd] = sx(in_tdata[39:8]);
          OP_CAST: hit_queue.push_back(cast_ray(in_tdata));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.hit = out_tuser[0];
        got.kind = out_tuser[1];
        got.index = out_tdata[3:0];
        got.cx = out_tdata[35:4];
        got.cy = out_tdata[67:36];
        got.cz = out_tdata[99:68];
        if (hit_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result item with none expected", $realtime);
        end else begin
          want = hit_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: hit %b/%b kind %b/%b index %0d/%0d x %h/%h y %h/%h z %h/%h",
                       $realtime, want.hit, got.hit, want.kind, got.kind, want.index,
                       got.index, want.cx, got.cx, want.cy, got.cy, want.cz, got.cz);
          end
        end
      end
    end
    errors <= mismatches;
    pending <= hit_queue.size();
  end

endmodule

[test/ray_sphere_obb_first_hit_test.sv]
// Stimulus and verdict for the first-hit ray caster, with its checker beside it.
`timescale 1ns / 100ps
module ray_sphere_obb_first_hit_test;
  import rsob_pkg::*;

  localparam logic [2:0] ADDR_SPHERE_COUNT = 3'd0;
  localparam logic [2:0] ADDR_BOX_COUNT    = 3'd4;
  // Cycle limit of the run, with a wide margin over what the run needs.
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  logic [231:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         psel, penable, pwrite, pready;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           errors, pending;

  // Idle percentages of the sender and the receiver; the mode picks the pair.
  int idle_mode = 0;
  int send_idle = 38;
  int recv_idle = 67;
  int cycles = 0;

  always #5 clk = ~clk;

  ray_sphere_obb_first_hit DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ray_sphere_obb_first_hit_check checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls per the idle mode. On entering the last mode it
  // holds off once for a long stretch, so that a result waits in the output
  // register, the next cast finishes behind it and the input stalls.
  initial begin
    int hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_mode == 2 && !held) begin
        held = 1'b1;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic set_mode(int m);
    idle_mode = m;
    send_idle = (m == 0) ? 38 : (m == 1) ? 67 : 0;
    recv_idle = (m == 0) ? 67 : (m == 1) ? 38 : 0;
  endtask

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high into the next item unless the sender decides to idle first.
  task automatic send(op_t op, logic [231:0] data);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load(op_t op, logic [3:0] ent, logic [3:0] wd, logic [31:0] val);
    logic [231:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    d[3:0] = ent;
    d[7:4] = wd;
    d[39:8] = val;
    send(op, d);
  endtask

  task automatic cast(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                      logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
    logic [231:0] d;
    d = '0;
    d[39:0] = {$urandom, 8'($urandom)};
    d[231:40] = {mz, my, mx, oz, oy, ox};
    send(OP_CAST, d);
  endtask

  // Waits until every cast has answered, then lets a possible load settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Register write: setup cycle, then the access cycle in which it lands.
  task automatic reg_write(logic [2:0] addr, logic [4:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {27'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_counts(logic [4:0] ns, logic [4:0] nb);
    drain();
    reg_write(ADDR_SPHERE_COUNT, ns);
    reg_write(ADDR_BOX_COUNT, nb);
  endtask

  // Signed Q16.16 value drawn from -span..+span.
  function automatic logic [31:0] near(int span);
    return 32'($urandom_range(0, 2*span*65536) - span*65536);
  endfunction

  // Plausible geometry, so that hits are common; one word in ten is raw noise.
  function automatic logic [31:0] table_word(op_t op, logic [3:0] wd);
    if ($urandom_range(9) == 0) return $urandom;
    if (wd < 3) return near(8);
    if (op == OP_LOAD_SPH || wd >= 12) return 32'($urandom_range(Q_ONE/2, 4*Q_ONE));
    case ($urandom_range(3))
      0: return 32'h0;
      1: return Q_ONE;
      2: return -Q_ONE;
      default: return 32'h0000_B505;
    endcase
  endfunction

  task automatic random_cast();
    logic [31:0] o[3], m[3];
    int pick;
    pick = $urandom_range(99);
    foreach (o[k]) o[k] = ($urandom_range(99) < 85) ? near(12) : $urandom;
    foreach (m[k]) m[k] = (pick < 8) ? 32'h0 : (pick < 90) ? near(16) : $urandom;
    cast(o[0], o[1], o[2], m[0], m[1], m[2]);
  endtask

  task automatic random_item();
    int pick;
    op_t op;
    logic [3:0] wd;
    pick = $urandom_range(99);
    op = ($urandom_range(1) == 0) ? OP_LOAD_SPH : OP_LOAD_BOX;
    if (pick < 55) begin
      wd = 4'($urandom_range(0, (op == OP_LOAD_SPH) ? SPH_WORDS-1 : BOX_WORDS-1));
      load(op, 4'($urandom), wd, table_word(op, wd));
    end else if (pick < 93) begin
      random_cast();
    end else if (pick < 97) begin
      load(OP_NONE, 4'($urandom), 4'($urandom), $urandom);
    end else begin
      // Word index past the end of the entry: ignored by the block.
      wd = 4'($urandom_range((op == OP_LOAD_SPH) ? SPH_WORDS : BOX_WORDS, 15));
      load(op, 4'($urandom), wd, $urandom);
    end
  endtask

  initial begin
    logic [4:0] chunk_spheres [8] = '{3, 1, 16, 0, 2, 31, 4, 2};
    logic [4:0] chunk_boxes   [8] = '{2, 4, 16, 3, 0, 31, 1, 5};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_NONE;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(0);

    // Every table entry is written before any count lets a cast read it.
    for (int e = 0; e < MAX_SPHERES; e++)
      for (int w = 0; w < SPH_WORDS; w++)
        load(OP_LOAD_SPH, 4'(e), 4'(w), table_word(OP_LOAD_SPH, 4'(w)));
    for (int e = 0; e < MAX_BOXES; e++)
      for (int w = 0; w < BOX_WORDS; w++)
        load(OP_LOAD_BOX, 4'(e), 4'(w), table_word(OP_LOAD_BOX, 4'(w)));

    // Nothing enabled: a cast must report no hit.
    cast(32'h0, 32'h0, 32'h0, 10*Q_ONE, 32'h0, 32'h0);

    // A unit sphere at x=5 and an axis-aligned unit box at y=5.
    load(OP_LOAD_SPH, 4'd0, 4'd0, 5*Q_ONE);
    load(OP_LOAD_SPH, 4'd0, 4'd1, 32'h0);
    load(OP_LOAD_SPH, 4'd0, 4'd2, 32'h0);
    load(OP_LOAD_SPH, 4'd0, 4'd3, Q_ONE);
    for (int w = 0; w < BOX_WORDS; w++)
      load(OP_LOAD_BOX, 4'd0, 4'(w),
           (w == 1) ? 5*Q_ONE : (w == 3 || w == 7 || w == 11 || w >= 12) ? Q_ONE : 32'h0);
    set_counts(5'd1, 5'd1);

    cast(32'h0, 32'h0, 32'h0, 10*Q_ONE, 32'h0, 32'h0);      // sphere hit ahead
    cast(32'h0, 32'h0, 32'h0, 32'h0, 10*Q_ONE, 32'h0);      // sphere missed, box hit
    cast(5*Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);       // zero move inside sphere
    cast(5*Q_ONE, Q_ONE/2, 32'h0, Q_ONE, 32'h0, 32'h0);     // inside sphere, t negative
    cast(32'h0, 20*Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0);      // zero move, nothing hit
    cast(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    cast(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load(OP_NONE, 4'd0, 4'd0, 32'hFFFF_FFFF);                // unknown operation
    load(OP_LOAD_SPH, 4'd15, 4'd15, 32'h7FFF_FFFF);          // word past the sphere entry
    load(OP_LOAD_BOX, 4'd15, 4'd15, 32'h8000_0000);          // word past the box entry
    cast(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 10*Q_ONE);

    // Counts above the table size are limited to the full tables.
    set_counts(5'd31, 5'd31);
    cast(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    cast(32'h0, -3*Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0);

    // Random part in chunks, each under its own counts; the idle mode steps
    // from sender-light to receiver-light to none.
    for (int c = 0; c < 8; c++) begin
      set_counts(chunk_spheres[c], chunk_boxes[c]);
      set_mode((c < 3) ? 0 : (c < 6) ? 1 : 2);
      for (int n = 0; n < 100; n++) random_item();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[ray_sphere_obb_first_hit.f]
hw/rtl/rsob_pkg.sv
hw/rtl/rsob_ram.sv
hw/rtl/rsob_alu.sv
hw/rtl/ray_sphere_obb_first_hit.sv
test/ray_sphere_obb_first_hit_check.sv
test/ray_sphere_obb_first_hit_test.sv
